// ===== hdl/dsac_pkg.sv =====
// Shared types, character codes and the month-length table for the
// DD-MM-YYYY date compare block. No dependencies.
package dsac_pkg;

   localparam logic [7:0] CHAR_NUL  = 8'h00;
   localparam logic [7:0] CHAR_DASH = 8'h2D;
   localparam logic [7:0] CHAR_ZERO = 8'h30;
   localparam logic [7:0] CHAR_NINE = 8'h39;

   // character positions within DD-MM-YYYY
   localparam logic [3:0] POS_DAY_HI     = 4'd0;
   localparam logic [3:0] POS_DAY_LO     = 4'd1;
   localparam logic [3:0] POS_DASH_DAY   = 4'd2;
   localparam logic [3:0] POS_MONTH_HI   = 4'd3;
   localparam logic [3:0] POS_MONTH_LO   = 4'd4;
   localparam logic [3:0] POS_DASH_MONTH = 4'd5;
   localparam logic [3:0] POS_YEAR_THOU  = 4'd6;
   localparam logic [3:0] POS_YEAR_HUND  = 4'd7;
   localparam logic [3:0] POS_YEAR_TENS  = 4'd8;
   localparam logic [3:0] POS_YEAR_ONES  = 4'd9;
   localparam logic [3:0] DATE_LEN       = 4'd10;
   localparam logic [3:0] POS_SAT        = 4'd11;

   localparam logic [6:0] MONTH_MIN     = 7'd1;
   localparam logic [6:0] MONTH_MAX     = 7'd12;
   localparam logic [6:0] DAY_MIN       = 7'd1;
   localparam logic [6:0] FEB_LEAP_DAYS = 7'd29;
   localparam logic [6:0] MONTH_FEB     = 7'd2;

   typedef enum logic [1:0] {
      VERDICT_INVALID      = 2'd0,
      VERDICT_SAME         = 2'd1,
      VERDICT_FIRST_OLDER  = 2'd2,
      VERDICT_SECOND_OLDER = 2'd3
   } verdict_type;

   // what one lane reports about its accumulated date
   typedef struct packed {
      logic       ok;
      logic [6:0] day;
      logic [6:0] month;
      logic [13:0] year;
   } lane_date_type;

   // days in a non-leap month, month already known to be 1..12
   function automatic logic [6:0] month_days(input logic [3:0] month);
      logic [6:0] days;
      case (month)
         4'd2:                     days = 7'd28;
         4'd4, 4'd6, 4'd9, 4'd11:  days = 7'd30;
         default:                  days = 7'd31;
      endcase
      return days;
   endfunction

endpackage

// ===== hdl/date_string_age_compare.sv =====
// Top level of the DD-MM-YYYY date compare block: position tracking, the
// two string lanes and the merge stage. Depends on dsac_pkg, dsac_lane and
// dsac_merge.
//
// Usage:
//   Request channel (req_valid/req_ready): one character of each string per
//   request. A zero byte ends that string; a request with both bytes zero
//   ends the comparison and is the only one that yields a response.
//   Response channel (rsp_valid/rsp_ready): rsp_verdict is 0 invalid,
//   1 same age, 2 first older, 3 second older.
//   Throughput: one request per cycle while req_ready is high; each lane
//   checks a character combinationally and accumulates it as it is accepted.
//   Response: the verdict is registered and shows in the cycle after the
//   terminating request is accepted; the lanes clear at the edge that
//   registers it, so the next date pair can start in the following cycle.
//   Stall: the verdict sits in the output register while rsp_ready is low;
//   requests keep flowing while the register is empty or being drained,
//   and req_ready drops only when a held verdict is not taken.
//   Reset: synchronous, clears the position, the lanes and the output valid.
module date_string_age_compare import dsac_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_char_first,
   input  logic [7:0] req_char_second,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [1:0] rsp_verdict
);

   logic          accept;
   logic          terminate;
   logic          fault_first, fault_second;
   logic          step_fault;
   logic          acc_en;
   logic          clear;
   logic [3:0]    pos_ff, pos_in;
   logic          format_error_ff, format_error_in;
   lane_date_type date_first, date_second;

   assign req_ready = !rsp_valid || rsp_ready;
   assign accept    = req_valid && req_ready;
   assign terminate = (req_char_first == CHAR_NUL) && (req_char_second == CHAR_NUL);
   assign clear     = accept && terminate;

   // a zero byte in one string only fails the lane check at every position
   assign step_fault = (pos_ff >= DATE_LEN) || fault_first || fault_second;
   assign acc_en     = accept && !terminate && !step_fault;

   always_comb begin
      pos_in          = pos_ff;
      format_error_in = format_error_ff;
      if (accept) begin
         if (terminate) begin
            pos_in          = '0;
            format_error_in = 1'b0;
         end else begin
            if (step_fault) begin
               format_error_in = 1'b1;
            end
            if (pos_ff < POS_SAT) begin
               pos_in = pos_ff + 4'd1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff          <= '0;
         format_error_ff <= 1'b0;
      end else begin
         pos_ff          <= pos_in;
         format_error_ff <= format_error_in;
      end
   end

   dsac_lane u_lane_first (
      .clock   (clock),
      .reset   (reset),
      .char_in (req_char_first),
      .pos     (pos_ff),
      .acc_en  (acc_en),
      .clear   (clear),
      .fault   (fault_first),
      .date    (date_first)
   );

   dsac_lane u_lane_second (
      .clock   (clock),
      .reset   (reset),
      .char_in (req_char_second),
      .pos     (pos_ff),
      .acc_en  (acc_en),
      .clear   (clear),
      .fault   (fault_second),
      .date    (date_second)
   );

   dsac_merge u_merge (
      .clock       (clock),
      .reset       (reset),
      .load        (clear),
      .format_ok   (!format_error_ff && (pos_ff == DATE_LEN)),
      .date_first  (date_first),
      .date_second (date_second),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_verdict (rsp_verdict)
   );

endmodule

// ===== hdl/dsac_lane.sv =====
// One string lane: checks each character, accumulates day, month and year,
// and validates the finished date. Depends on dsac_pkg.
module dsac_lane import dsac_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic [7:0]    char_in,
   input  logic [3:0]    pos,
   input  logic          acc_en,
   input  logic          clear,
   output logic          fault,
   output lane_date_type date
);

   logic [6:0]  day_ff, day_in;
   logic [6:0]  month_ff, month_in;
   logic [13:0] year_ff, year_in;
   logic [1:0]  hi_mod4_ff, hi_mod4_in;   // first two year digits, mod 4
   logic [3:0]  tens_ff, tens_in;
   logic [3:0]  ones_ff, ones_in;
   logic [3:0]  digit;
   logic        is_digit;
   logic        leap;
   logic [5:0]  low_sum;
   logic [6:0]  limit;

   assign digit    = char_in[3:0];
   assign is_digit = (char_in >= CHAR_ZERO) && (char_in <= CHAR_NINE);

   always_comb begin
      if ((pos == POS_DASH_DAY) || (pos == POS_DASH_MONTH)) begin
         fault = (char_in != CHAR_DASH);
      end else begin
         fault = !is_digit;
      end
   end

   always_comb begin
      day_in     = day_ff;
      month_in   = month_ff;
      year_in    = year_ff;
      hi_mod4_in = hi_mod4_ff;
      tens_in    = tens_ff;
      ones_in    = ones_ff;
      if (acc_en) begin
         case (pos) inside
            [POS_DAY_HI:POS_DAY_LO]: begin
               day_in = 7'((day_ff << 3) + (day_ff << 1) + 7'(digit));
            end
            [POS_MONTH_HI:POS_MONTH_LO]: begin
               month_in = 7'((month_ff << 3) + (month_ff << 1) + 7'(digit));
            end
            [POS_YEAR_THOU:POS_YEAR_ONES]: begin
               year_in = 14'((year_ff << 3) + (year_ff << 1) + 14'(digit));
               if (pos == POS_YEAR_TENS) begin
                  tens_in = digit;
               end else if (pos == POS_YEAR_ONES) begin
                  ones_in = digit;
               end else begin
                  // 10 is 2 mod 4
                  hi_mod4_in = 2'((hi_mod4_ff << 1) + digit[1:0]);
               end
            end
            default: begin
            end
         endcase
      end
      if (clear) begin
         day_in     = '0;
         month_in   = '0;
         year_in    = '0;
         hi_mod4_in = '0;
         tens_in    = '0;
         ones_in    = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         day_ff     <= '0;
         month_ff   <= '0;
         year_ff    <= '0;
         hi_mod4_ff <= '0;
         tens_ff    <= '0;
         ones_ff    <= '0;
      end else begin
         day_ff     <= day_in;
         month_ff   <= month_in;
         year_ff    <= year_in;
         hi_mod4_ff <= hi_mod4_in;
         tens_ff    <= tens_in;
         ones_ff    <= ones_in;
      end
   end

   // Gregorian rule from the digits: a century year is leap when its first
   // two digits divide by 4, any other year when its last two digits do.
   assign low_sum = 6'({tens_ff, 1'b0}) + 6'(ones_ff);

   always_comb begin
      if ((tens_ff == 4'd0) && (ones_ff == 4'd0)) begin
         leap = (hi_mod4_ff == 2'd0);
      end else begin
         leap = (low_sum[1:0] == 2'b00);
      end
      if ((month_ff == MONTH_FEB) && leap) begin
         limit = FEB_LEAP_DAYS;
      end else begin
         limit = month_days(month_ff[3:0]);
      end
   end

   assign date.ok    = (month_ff >= MONTH_MIN) && (month_ff <= MONTH_MAX) &&
                       (day_ff >= DAY_MIN) && (day_ff <= limit);
   assign date.day   = day_ff;
   assign date.month = month_ff;
   assign date.year  = year_ff;

endmodule

// ===== hdl/dsac_merge.sv =====
// Merge stage: combines both lanes' dates into one verdict and holds it in
// the output register until taken. Depends on dsac_pkg.
module dsac_merge import dsac_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          load,
   input  logic          format_ok,
   input  lane_date_type date_first,
   input  lane_date_type date_second,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   output logic [1:0]    rsp_verdict
);

   logic        valid_ff, valid_in;
   verdict_type verdict_ff, verdict_in;

   always_comb begin
      verdict_in = VERDICT_INVALID;
      if (format_ok && date_first.ok && date_second.ok) begin
         if (date_first.year != date_second.year) begin
            verdict_in = (date_first.year < date_second.year) ?
                         VERDICT_FIRST_OLDER : VERDICT_SECOND_OLDER;
         end else if (date_first.month != date_second.month) begin
            verdict_in = (date_first.month < date_second.month) ?
                         VERDICT_FIRST_OLDER : VERDICT_SECOND_OLDER;
         end else if (date_first.day != date_second.day) begin
            verdict_in = (date_first.day < date_second.day) ?
                         VERDICT_FIRST_OLDER : VERDICT_SECOND_OLDER;
         end else begin
            verdict_in = VERDICT_SAME;
         end
      end
   end

   always_comb begin
      valid_in = valid_ff;
      if (valid_ff && rsp_ready) begin
         valid_in = 1'b0;
      end
      if (load) begin
         valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         verdict_ff <= verdict_in;
      end
   end

   assign rsp_valid   = valid_ff;
   assign rsp_verdict = verdict_ff;

endmodule

// ===== hdl/dsac_checker.sv =====
// Port-level checks for the date compare block, attached to the top level
// by the bind below. Depends on dsac_pkg and the top level's ports.
module dsac_checker import dsac_pkg::*; (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic [7:0] req_char_first,
   input logic [7:0] req_char_second,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [1:0] rsp_verdict
);

   logic req_fire;
   logic req_last;

   assign req_fire = req_valid && req_ready;
   assign req_last = (req_char_first == CHAR_NUL) && (req_char_second == CHAR_NUL);

   // a terminating request always yields a verdict in the next cycle
   assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_last) |=> rsp_valid)
      else $error("terminating request produced no verdict");

   // other requests never create a verdict
   assert property (@(posedge clock) disable iff (reset)
      (!rsp_valid && !(req_fire && req_last)) |=> !rsp_valid)
      else $error("verdict appeared without a terminating request");

   // requests flow whenever no verdict is held
   assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("request stalled with empty output register");

   // a stalled verdict holds
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_verdict)))
      else $error("stalled verdict changed or dropped");

endmodule

bind date_string_age_compare dsac_checker u_dsac_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_ready       (req_ready),
   .req_char_first  (req_char_first),
   .req_char_second (req_char_second),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_verdict     (rsp_verdict)
);
